FILE: src/awh_pkg.sv
// ----------------------------------------------------------------------------
// awh_pkg
// shared constants, operation codes and types of the auto-window histogram
// ----------------------------------------------------------------------------
package awh_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int VALUE_W      = 16;
    localparam int COUNT_W      = 32;

    // slot index and window length widths
    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);

    // epoch tag kept next to each count; tag zero marks a swept entry
    localparam int TAG_W = 8;
    localparam logic [TAG_W-1:0] EPOCH_FIRST = TAG_W'(1);
    localparam logic [TAG_W-1:0] EPOCH_LAST  = {TAG_W{1'b1}};
    localparam logic [TAG_W-1:0] EPOCH_NONE  = '0;

    localparam int ENTRY_W = TAG_W + COUNT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // stream packing
    localparam int IN_FIELDS_W  = 2 + VALUE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = COUNT_W + 2;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // operation codes
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // window decision for the item being accepted
    typedef struct packed {
        logic hit;      // value lies in the current window
        logic add_ok;   // an add of this value fits within the depth
    } awh_win_t;

endpackage

FILE: src/awh_window.sv
// ----------------------------------------------------------------------------
// awh_window
// window base and length registers with the widen / reject decision
// ----------------------------------------------------------------------------
module awh_window (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [1:0]                         mode,
    input  logic signed [awh_pkg::VALUE_W-1:0] value,
    output awh_pkg::awh_win_t                  win
);
    import awh_pkg::*;

    localparam int EXT_W = VALUE_W + 2;
    localparam logic signed [EXT_W-1:0] DEPTH_X = EXT_W'(WINDOW_DEPTH);
    localparam logic signed [EXT_W-1:0] ONE_X   = EXT_W'(1);

    logic signed [VALUE_W-1:0] base_reg;
    logic signed [VALUE_W-1:0] base_next;
    logic        [LEN_W-1:0]   len_reg;
    logic        [LEN_W-1:0]   len_next;

    logic signed [EXT_W-1:0] v_x;
    logic signed [EXT_W-1:0] base_x;
    logic signed [EXT_W-1:0] len_x;
    logic signed [EXT_W-1:0] end_x;
    logic signed [EXT_W-1:0] nlen_dn;
    logic signed [EXT_W-1:0] nlen_up;
    logic                    empty;
    logic                    below;
    logic                    above;
    logic                    fit_dn;
    logic                    fit_up;

    assign v_x    = EXT_W'(value);
    assign base_x = EXT_W'(base_reg);
    assign len_x  = EXT_W'(len_reg);
    assign end_x  = base_x + len_x;

    assign empty  = (len_reg == '0);
    assign below  = !empty && (v_x < base_x);
    assign above  = !empty && (v_x >= end_x);

    // new length when the window grows toward the value
    assign nlen_dn = end_x - v_x;
    assign nlen_up = v_x - base_x + ONE_X;
    assign fit_dn  = (nlen_dn <= DEPTH_X);
    assign fit_up  = (nlen_up <= DEPTH_X);

    assign win.hit    = !empty && !below && !above;
    assign win.add_ok = !(below && !fit_dn) && !(above && !fit_up);

    always_comb
    begin
        base_next = base_reg;
        len_next  = len_reg;
        if (accept)
        begin
            if (mode == MODE_CLEAR)
            begin
                base_next = '0;
                len_next  = '0;
            end
            else if (mode == MODE_ADD && win.add_ok)
            begin
                if (empty)
                begin
                    base_next = value;
                    len_next  = LEN_W'(1);
                end
                else if (below)
                begin
                    base_next = value;
                    len_next  = nlen_dn[LEN_W-1:0];
                end
                else if (above)
                begin
                    len_next = nlen_up[LEN_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            len_reg  <= '0;
        end
        else
        begin
            base_reg <= base_next;
            len_reg  <= len_next;
        end
    end

endmodule

FILE: src/auto_window_histogram_top.sv
// ----------------------------------------------------------------------------
// auto_window_histogram_top
// occurrence counter over a self-widening window of signed values
// ----------------------------------------------------------------------------
// Each input transaction carries an operation (add, query, clear) and a
// signed 16-bit value and yields exactly one result transaction with the
// value's count, whether it lies in the window, and whether an add was
// refused. Counts live in a 1024 x 40-bit single-port-write memory with a
// registered read; each entry holds a 32-bit count and an 8-bit epoch tag.
// An entry whose tag differs from the current epoch reads as zero, so
// widening the window needs no pass over the memory, and neither does a
// clear but the one on which the epoch wraps. For each item, the accept
// cycle computes the window decision and issues the memory read, and the
// next cycle does the saturating increment, writes the entry back and loads
// the output register. The output register lets the next item be accepted
// in the same cycle the previous result is taken; no item is accepted
// during the read-modify-write cycle of the one before it. After reset the
// block runs a clearing pass over all 1024 entries before taking its
// first item, and the same pass follows every 255th clear, as the epoch wraps.
// ----------------------------------------------------------------------------
module auto_window_histogram_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // input side
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [awh_pkg::IN_TDATA_W-1:0]   s_tdata,   // mode[1:0], value[17:2]
    // result side
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [awh_pkg::OUT_TDATA_W-1:0]  m_tdata    // count[31:0], in_window[32],
                                                        // rejected[33]
);
    import awh_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_SWEEP = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RMW   = 2'd2;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [SLOT_W-1:0]       sweep_reg;
    logic [SLOT_W-1:0]       sweep_next;
    logic [TAG_W-1:0]        epoch_reg;
    logic [TAG_W-1:0]        epoch_next;

    // fields of the incoming transaction
    logic [1:0]              in_mode;
    logic signed [VALUE_W-1:0] in_value;
    logic [VALUE_W-1:0]      in_offset;
    logic [SLOT_W-1:0]       in_slot;
    logic                    s_acc;
    awh_win_t                win;

    // item held for the read-modify-write cycle
    logic                    is_add_reg;
    logic                    is_clr_reg;
    logic                    add_ok_reg;
    logic                    hit_reg;
    logic [SLOT_W-1:0]       slot_reg;

    // count memory
    logic [ENTRY_W-1:0]      mem [WINDOW_DEPTH];
    logic [ENTRY_W-1:0]      rdata_reg;
    logic                    mem_we;
    logic [SLOT_W-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]      mem_wdata;

    logic [TAG_W-1:0]        rd_tag;
    logic [COUNT_W-1:0]      rd_count;
    logic [COUNT_W-1:0]      inc_count;

    // output register
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic [COUNT_W-1:0]      count_reg;
    logic                    in_window_reg;
    logic                    rejected_reg;

    assign in_mode  = s_tdata[1:0];
    assign in_value = s_tdata[2 +: VALUE_W];

    // slot = (value + half range) mod depth: flip the sign bit, keep low bits
    assign in_offset = {~in_value[VALUE_W-1], in_value[VALUE_W-2:0]};
    assign in_slot   = in_offset[SLOT_W-1:0];

    // take a new item only when the output register is free by next cycle
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;

    awh_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (s_acc),
        .mode   (in_mode),
        .value  (in_value),
        .win    (win)
    );

    // a stale epoch tag means the entry was never counted in this window
    assign rd_tag    = rdata_reg[COUNT_W +: TAG_W];
    assign rd_count  = (rd_tag == epoch_reg) ? rdata_reg[COUNT_W-1:0] : '0;
    assign inc_count = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_W'(1);

    // memory write port: clearing pass or add write-back
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = {epoch_reg, inc_count};
        if (state_reg == ST_SWEEP)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = {EPOCH_NONE, {COUNT_W{1'b0}}};
        end
        else if (state_reg == ST_RMW && is_add_reg && add_ok_reg)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[in_slot];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        epoch_next = epoch_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                sweep_next = sweep_reg + SLOT_W'(1);
                if (sweep_reg == SLOT_W'(WINDOW_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW:
            begin
                state_next = ST_IDLE;
                if (is_clr_reg)
                begin
                    // epoch wrap: old tags could alias, so sweep the memory
                    if (epoch_reg == EPOCH_LAST)
                    begin
                        epoch_next = EPOCH_FIRST;
                        sweep_next = '0;
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + TAG_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            sweep_reg <= '0;
            epoch_reg <= EPOCH_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            epoch_reg <= epoch_next;
        end
    end

    // capture the item and its window decision
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            is_add_reg <= (in_mode == MODE_ADD);
            is_clr_reg <= (in_mode == MODE_CLEAR);
            add_ok_reg <= win.add_ok;
            hit_reg    <= win.hit;
            slot_reg   <= in_slot;
        end
    end

    // output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (state_reg == ST_RMW)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RMW)
        begin
            count_reg     <= '0;
            in_window_reg <= 1'b0;
            rejected_reg  <= 1'b0;
            if (is_add_reg)
            begin
                if (add_ok_reg)
                begin
                    count_reg     <= inc_count;
                    in_window_reg <= 1'b1;
                end
                else
                begin
                    rejected_reg <= 1'b1;
                end
            end
            else if (!is_clr_reg && hit_reg)
            begin
                count_reg     <= rd_count;
                in_window_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({rejected_reg, in_window_reg, count_reg});

endmodule

FILE: src/awh_checker.sv
// ----------------------------------------------------------------------------
// awh_checker
// port-level checks of the auto-window histogram, bound to the top level
// ----------------------------------------------------------------------------
module awh_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [awh_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [awh_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import awh_pkg::*;

    logic s_acc;
    logic out_inw;
    logic out_rej;
    logic [COUNT_W-1:0] out_count;

    assign s_acc     = s_tvalid && s_tready && (s_tdata[1:0] == s_tdata[1:0]);
    assign out_count = m_tdata[COUNT_W-1:0];
    assign out_inw   = m_tdata[COUNT_W];
    assign out_rej   = m_tdata[COUNT_W+1];

    // a new transaction is never taken while a result is stuck
    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |-> (!m_tvalid || m_tready))
        else $error("input accepted while result stalled");

    // every accepted item yields its result once its read-modify-write cycle has loaded the output
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |-> ##2 m_tvalid)
        else $error("result missing two cycles after accept");

    // a refused add reports nothing else
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_rej) |-> (!out_inw && out_count == '0))
        else $error("rejected result carries count or in_window");

    // a nonzero count only comes from inside the window
    a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_count != '0) |-> out_inw)
        else $error("nonzero count outside window");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind auto_window_histogram_top awh_checker u_awh_checker (.*);
